// ----- hdl/sorted_table_binary_search_core_assert.svh -----
// Assertion macros for the sorted-table binary search core.
`ifndef SORTED_TABLE_BINARY_SEARCH_CORE_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define STBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
`define STBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define STBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define STBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- hdl/stbs_pkg.sv -----
// Shared constants and controller/datapath interface types for the search core.
package stbs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int SIZE_W      = 11;
    localparam int DATA_W      = 32;
    localparam int S_TDATA_W   = 80;
    localparam int M_TDATA_W   = 16;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef struct packed {
        logic wr;
        logic load;
        logic rd;
        logic step;
        logic push;
        logic push_miss;
    } ctrl_cmd_t;

    typedef struct packed {
        logic             bounds_eq;
        logic             size_zero;
        logic             out_free;
        logic [IDX_W-1:0] last_idx;
    } dp_status_t;

endpackage

// ----- hdl/stbs_dpath.sv -----
// Datapath: table memory, bisection bounds, key, size register and output register.
module stbs_dpath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  stbs_pkg::ctrl_cmd_t           cmd,
    output stbs_pkg::dp_status_t          status,
    input  logic                          cfg_valid,
    input  logic [stbs_pkg::SIZE_W-1:0]   cfg_data,
    input  logic [stbs_pkg::IDX_W-1:0]    entry_index,
    input  logic signed [stbs_pkg::DATA_W-1:0] entry_value,
    input  logic signed [stbs_pkg::DATA_W-1:0] search_key,
    input  logic                          m_tready,
    output logic                          out_valid,
    output logic                          found,
    output logic [stbs_pkg::IDX_W-1:0]    match_index
);
    import stbs_pkg::*;

    logic signed [DATA_W-1:0] mem [TABLE_DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;
    logic signed [DATA_W-1:0] key_reg;
    logic [SIZE_W-1:0]        size_reg;
    logic [IDX_W-1:0]         bot_reg, bot_next;
    logic [IDX_W-1:0]         top_reg, top_next;
    logic [IDX_W-1:0]         mid;
    logic [IDX_W-1:0]         rd_addr;
    logic [SIZE_W-1:0]        size_clamped;
    logic                     out_valid_reg, out_valid_next;
    logic                     found_reg;
    logic [IDX_W-1:0]         match_reg;
    logic                     hit;

    assign size_clamped = (size_reg > SIZE_W'(TABLE_DEPTH)) ? SIZE_W'(TABLE_DEPTH) : size_reg;
    assign mid          = top_reg - ((top_reg - bot_reg) >> 1);
    assign rd_addr      = (bot_reg == top_reg) ? top_reg : mid;
    assign hit          = (key_reg == rd_data_reg);

    assign status.bounds_eq = (bot_reg == top_reg);
    assign status.size_zero = (size_reg == '0);
    assign status.out_free  = !out_valid_reg || m_tready;
    assign status.last_idx  = IDX_W'(size_clamped - SIZE_W'(1));

    always_ff @(posedge clk) begin
        if (cmd.wr) begin
            mem[entry_index] <= entry_value;
        end
        if (cmd.rd) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        bot_next = bot_reg;
        top_next = top_reg;
        if (cmd.load) begin
            bot_next = '0;
            top_next = status.last_idx;
        end else if (cmd.step) begin
            if (key_reg < rd_data_reg) begin
                top_next = mid - IDX_W'(1);
            end else begin
                bot_next = mid;
            end
        end
    end

    always_ff @(posedge clk) begin
        bot_reg <= bot_next;
        top_reg <= top_next;
        if (cmd.load) begin
            key_reg <= search_key;
        end
        if (cmd.push) begin
            found_reg <= hit;
            match_reg <= hit ? top_reg : '0;
        end else if (cmd.push_miss) begin
            found_reg <= 1'b0;
            match_reg <= '0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.push || cmd.push_miss) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            size_reg      <= SIZE_W'(1);
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                size_reg <= cfg_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign match_index = match_reg;

endmodule

// ----- hdl/stbs_ctrl.sv -----
// Controller: sequences table writes and the probe/compare loop of a search.
module stbs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_command,
    output logic                  in_ready,
    input  stbs_pkg::dp_status_t  status,
    output stbs_pkg::ctrl_cmd_t   cmd
);
    import stbs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RD   = 4'b0010,
        ST_CMP  = 4'b0100,
        ST_ZERO = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) begin
                    if (in_command == CMD_WRITE) begin
                        cmd.wr = 1'b1;
                    end else if (status.size_zero) begin
                        state_next = ST_ZERO;
                    end else begin
                        cmd.load   = 1'b1;
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (status.bounds_eq) begin
                    if (status.out_free) begin
                        cmd.push   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    cmd.step   = 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_ZERO:
            begin
                if (status.out_free) begin
                    cmd.push_miss = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hdl/sorted_table_binary_search_core.sv -----
// Top level of the sorted-table binary search core.
//
//  channel   direction  tvalid/tready       payload
//  s_*       in         s_tvalid/s_tready   tuser=command; tdata=index,value,key
//  m_*       out        m_tvalid/m_tready   tuser=found; tdata=match_index
//  cfg_*     in         cfg_valid/cfg_ready cfg_data=table_size
//
// Write beat: memory written at the accepting edge.
// Search beat: ceil(log2(n)) bisection steps for n entries, each one registered
// memory read plus one compare, then a final read and compare at the remaining index.
// Reset: table_size = 1, no result pending; table contents stay undefined.
// A finished result holds in the output register; a new beat is taken meanwhile.
`include "sorted_table_binary_search_core_assert.svh"

module sorted_table_binary_search_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [9:0] entry_index, [41:10] entry_value, [73:42] search_key, [79:74] zero
    input  logic [stbs_pkg::S_TDATA_W-1:0]    s_tdata,
    // [0] command
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [9:0] match_index, [15:10] zero
    output logic [stbs_pkg::M_TDATA_W-1:0]    m_tdata,
    // [0] found
    output logic                              m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [stbs_pkg::SIZE_W-1:0]       cfg_data
);
    import stbs_pkg::*;

    ctrl_cmd_t         cmd;
    dp_status_t        status;
    logic [IDX_W-1:0]  match_index;
    logic              found;

    assign cfg_ready = 1'b1;

    stbs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_command (s_tuser),
        .in_ready   (s_tready),
        .status     (status),
        .cmd        (cmd)
    );

    stbs_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .entry_index (s_tdata[IDX_W-1:0]),
        .entry_value (s_tdata[IDX_W+DATA_W-1:IDX_W]),
        .search_key  (s_tdata[IDX_W+2*DATA_W-1:IDX_W+DATA_W]),
        .m_tready    (m_tready),
        .out_valid   (m_tvalid),
        .found       (found),
        .match_index (match_index)
    );

    assign m_tuser = found;
    assign m_tdata = {{(M_TDATA_W-IDX_W){1'b0}}, match_index};

    `STBS_ASSERT_IMP(a_wr_on_beat, clk, rst_n, cmd.wr, s_tvalid && s_tready && !s_tuser)
    `STBS_ASSERT_IMP(a_push_room, clk, rst_n, cmd.push || cmd.push_miss, !m_tvalid || m_tready)
    `STBS_ASSERT_IMP(a_hit_in_range, clk, rst_n, m_tvalid && m_tuser, match_index <= status.last_idx)
    `STBS_ASSERT_NXT(a_result_valid, clk, rst_n, cmd.push || cmd.push_miss, m_tvalid)

endmodule
